FILE: hw/rtl/aldl_pkg.sv
package aldl_pkg;

   localparam int SLOTS  = 256;
   localparam int SLOT_W = 8;

   localparam logic [1:0] OP_INS_AFTER  = 2'd0;
   localparam logic [1:0] OP_INS_BEFORE = 2'd1;
   localparam logic [1:0] OP_REMOVE     = 2'd2;
   localparam logic [1:0] OP_LINEARIZE  = 2'd3;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_FULL         = 3'd1;
   localparam logic [2:0] ST_BAD_SLOT     = 3'd2;
   localparam logic [2:0] ST_BEFORE_EMPTY = 3'd3;
   localparam logic [2:0] ST_REMOVE_EMPTY = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic [SLOT_W-1:0]  slot;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [SLOT_W-1:0]  new_slot;
      logic signed [31:0] removed_value;
      logic               in_order;
      logic [SLOT_W-1:0]  count;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR_WR,
      CMD_LOAD,
      CMD_RD_SLOT,
      CMD_RD_FREE,
      CMD_CAP_FREE,
      CMD_WR1,
      CMD_WR2,
      CMD_WR3,
      CMD_WALK_RD,
      CMD_WALK_WR,
      CMD_REB_RD,
      CMD_REB_WR,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic ok;
      logic is_lin;
      logic count_zero;
      logic idx_last;
      logic walk_last;
   } dp_stat_type;

endpackage

FILE: hw/rtl/aldl_ctrl.sv
module aldl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_stall,
   input  aldl_pkg::dp_stat_type stat,
   output aldl_pkg::cmd_type    cmd,
   output logic                 req_stall,
   output logic                 rsp_valid
);
   import aldl_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_SLOT, S_RD_FREE, S_CHECK, S_WR1, S_WR2, S_WR3,
      S_WALK_RD, S_WALK_WR, S_REB_RD, S_REB_WR, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = CMD_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR_WR;
            if (stat.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_RD_SLOT;
            end
         end
         S_RD_SLOT: begin
            cmd = CMD_RD_SLOT;
            if (!stat.is_lin) state_in = S_RD_FREE;
            else if (stat.count_zero) state_in = S_REB_RD;
            else state_in = S_WALK_RD;
         end
         S_RD_FREE: begin
            cmd      = CMD_RD_FREE;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd      = CMD_CAP_FREE;
            state_in = stat.ok ? S_WR1 : S_FINISH;
         end
         S_WR1: begin
            cmd      = CMD_WR1;
            state_in = S_WR2;
         end
         S_WR2: begin
            cmd      = CMD_WR2;
            state_in = S_WR3;
         end
         S_WR3: begin
            cmd      = CMD_WR3;
            state_in = S_FINISH;
         end
         S_WALK_RD: begin
            cmd      = CMD_WALK_RD;
            state_in = S_WALK_WR;
         end
         S_WALK_WR: begin
            cmd      = CMD_WALK_WR;
            state_in = stat.walk_last ? S_REB_RD : S_WALK_RD;
         end
         S_REB_RD: begin
            cmd      = CMD_REB_RD;
            state_in = S_REB_WR;
         end
         S_REB_WR: begin
            cmd      = CMD_REB_WR;
            state_in = stat.idx_last ? S_FINISH : S_REB_RD;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd          = CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/aldl_dpath.sv
module aldl_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  aldl_pkg::cmd_type     cmd,
   input  aldl_pkg::req_type     req_data,
   output aldl_pkg::dp_stat_type stat,
   output aldl_pkg::rsp_type     rsp_data
);
   import aldl_pkg::*;

   // Node store, one array per field; value, next, prev and used share the write and read address, scratch uses idx_ff.
   logic signed [31:0] value_mem   [SLOTS];
   logic [SLOT_W-1:0]  next_mem    [SLOTS];
   logic [SLOT_W-1:0]  prev_mem    [SLOTS];
   logic               used_mem    [SLOTS];
   logic signed [31:0] scratch_mem [SLOTS];

   logic signed [31:0] rd_value_ff;
   logic [SLOT_W-1:0]  rd_next_ff, rd_prev_ff;
   logic               rd_used_ff;
   logic signed [31:0] scr_rd_ff;

   logic [SLOT_W-1:0] head_ff, tail_ff, free_ff, count_ff, idx_ff, cur_ff;
   logic              order_ff;
   logic [SLOT_W-1:0] head_in, tail_in, free_in, count_in, new_slot_in;
   logic              order_in;
   logic signed [31:0] removed_in;

   logic [1:0]         op_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic signed [31:0] val_ff;
   logic signed [31:0] s_value_ff;
   logic [SLOT_W-1:0]  s_next_ff, s_prev_ff, f_next_ff;
   logic               s_used_ff;
   rsp_type            rsp_ff;

   logic [SLOT_W-1:0]  rd_addr, wr_addr;
   logic               we_v, we_n, we_p, we_u;
   logic signed [31:0] wd_v;
   logic [SLOT_W-1:0]  wd_n, wd_p;
   logic               wd_u;
   logic [2:0]         status;
   logic               in_use, count_zero, ok;

   assign count_zero = (count_ff == '0);
   assign in_use     = (slot_ff != '0) && s_used_ff;
   assign ok         = (status == ST_OK);

   always_comb begin
      case (op_ff)
         OP_INS_AFTER: begin
            if (free_ff == '0) status = ST_FULL;
            else if (!((count_zero && slot_ff == '0) || in_use)) status = ST_BAD_SLOT;
            else status = ST_OK;
         end
         OP_INS_BEFORE: begin
            if (count_zero) status = ST_BEFORE_EMPTY;
            else if (free_ff == '0) status = ST_FULL;
            else if (!in_use) status = ST_BAD_SLOT;
            else status = ST_OK;
         end
         OP_REMOVE: begin
            if (count_zero) status = ST_REMOVE_EMPTY;
            else if (!in_use) status = ST_BAD_SLOT;
            else status = ST_OK;
         end
         default: status = ST_OK;
      endcase
   end

   assign stat.ok         = ok;
   assign stat.is_lin     = (op_ff == OP_LINEARIZE);
   assign stat.count_zero = count_zero;
   assign stat.idx_last   = (idx_ff == SLOT_W'(SLOTS - 1));
   assign stat.walk_last  = (idx_ff == count_ff);

   // Address and data for the link store, per command step.
   always_comb begin
      rd_addr = slot_ff;
      wr_addr = '0;
      we_v = 1'b0; we_n = 1'b0; we_p = 1'b0; we_u = 1'b0;
      wd_v = '0;   wd_n = '0;   wd_p = '0;   wd_u = 1'b0;
      unique case (cmd)
         CMD_CLEAR_WR: begin
            wr_addr = idx_ff;
            we_v = 1'b1; we_n = 1'b1; we_p = 1'b1; we_u = 1'b1;
            wd_n = idx_ff + SLOT_W'(1);
         end
         CMD_RD_FREE: rd_addr = free_ff;
         CMD_WALK_RD: rd_addr = cur_ff;
         CMD_WR1: begin
            case (op_ff)
               OP_INS_AFTER: begin
                  wr_addr = free_ff;
                  we_v = 1'b1; we_n = 1'b1; we_p = 1'b1; we_u = 1'b1;
                  wd_v = val_ff; wd_u = 1'b1; wd_p = slot_ff;
                  wd_n = count_zero ? '0 : s_next_ff;
               end
               OP_INS_BEFORE: begin
                  wr_addr = free_ff;
                  we_v = 1'b1; we_n = 1'b1; we_p = 1'b1; we_u = 1'b1;
                  wd_v = val_ff; wd_u = 1'b1; wd_p = s_prev_ff; wd_n = slot_ff;
               end
               OP_REMOVE: begin
                  if (s_prev_ff == '0) begin
                     wr_addr = s_next_ff;
                     we_p    = (s_next_ff != '0);
                  end else begin
                     wr_addr = s_prev_ff;
                     we_n    = 1'b1;
                     wd_n    = s_next_ff;
                  end
               end
               default: ;
            endcase
         end
         CMD_WR2: begin
            case (op_ff)
               OP_INS_AFTER: begin
                  wr_addr = slot_ff;
                  we_n    = !count_zero;
                  wd_n    = free_ff;
               end
               OP_INS_BEFORE: begin
                  wr_addr = slot_ff;
                  we_p    = 1'b1;
                  wd_p    = free_ff;
               end
               OP_REMOVE: begin
                  wr_addr = s_next_ff;
                  we_p    = (s_prev_ff != '0) && (tail_ff != slot_ff);
                  wd_p    = s_prev_ff;
               end
               default: ;
            endcase
         end
         CMD_WR3: begin
            case (op_ff)
               OP_INS_AFTER: begin
                  wr_addr = s_next_ff;
                  we_p    = (tail_ff != slot_ff);
                  wd_p    = free_ff;
               end
               OP_INS_BEFORE: begin
                  wr_addr = s_prev_ff;
                  we_n    = (head_ff != slot_ff);
                  wd_n    = free_ff;
               end
               OP_REMOVE: begin
                  wr_addr = slot_ff;
                  we_v = 1'b1; we_n = 1'b1; we_p = 1'b1; we_u = 1'b1;
                  wd_n = free_ff;
               end
               default: ;
            endcase
         end
         CMD_REB_WR: begin
            wr_addr = idx_ff;
            we_v = 1'b1; we_n = 1'b1; we_p = 1'b1; we_u = 1'b1;
            if (idx_ff <= count_ff) begin
               wd_v = scr_rd_ff;
               wd_u = 1'b1;
               wd_p = idx_ff - SLOT_W'(1);
               wd_n = (idx_ff == count_ff) ? '0 : idx_ff + SLOT_W'(1);
            end else begin
               wd_n = idx_ff + SLOT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Register updates at the end of an operation.
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      order_in    = order_ff;
      new_slot_in = '0;
      removed_in  = '0;
      case (op_ff)
         OP_INS_AFTER: begin
            if (ok) begin
               new_slot_in = free_ff;
               free_in     = f_next_ff;
               count_in    = count_ff + SLOT_W'(1);
               if (count_zero) head_in = free_ff;
               if (tail_ff == slot_ff) tail_in = free_ff;
               else order_in = 1'b0;
            end
         end
         OP_INS_BEFORE: begin
            if (ok) begin
               new_slot_in = free_ff;
               free_in     = f_next_ff;
               count_in    = count_ff + SLOT_W'(1);
               order_in    = 1'b0;
               if (head_ff == slot_ff) head_in = free_ff;
            end
         end
         OP_REMOVE: begin
            if (ok) begin
               removed_in = s_value_ff;
               count_in   = count_ff - SLOT_W'(1);
               free_in    = slot_ff;
               if (s_prev_ff == '0) begin
                  order_in = 1'b0;
                  if (head_ff == tail_ff) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = s_next_ff;
                  end
               end else if (tail_ff == slot_ff) begin
                  tail_in = s_prev_ff;
               end else begin
                  order_in = 1'b0;
               end
            end
         end
         default: begin
            head_in  = count_zero ? '0 : SLOT_W'(1);
            tail_in  = count_ff;
            free_in  = count_ff + SLOT_W'(1);
            order_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_v) value_mem[wr_addr] <= wd_v;
      if (we_n) next_mem[wr_addr]  <= wd_n;
      if (we_p) prev_mem[wr_addr]  <= wd_p;
      if (we_u) used_mem[wr_addr]  <= wd_u;
      if (cmd == CMD_WALK_WR) scratch_mem[idx_ff] <= rd_value_ff;
      rd_value_ff <= value_mem[rd_addr];
      rd_next_ff  <= next_mem[rd_addr];
      rd_prev_ff  <= prev_mem[rd_addr];
      rd_used_ff  <= used_mem[rd_addr];
      scr_rd_ff   <= scratch_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD) begin
         op_ff   <= req_data.op;
         slot_ff <= req_data.slot;
         val_ff  <= req_data.value;
      end
      if (cmd == CMD_RD_FREE) begin
         s_value_ff <= rd_value_ff;
         s_next_ff  <= rd_next_ff;
         s_prev_ff  <= rd_prev_ff;
         s_used_ff  <= rd_used_ff;
      end
      if (cmd == CMD_CAP_FREE) f_next_ff <= rd_next_ff;
      if (cmd == CMD_WALK_WR) cur_ff <= rd_next_ff;
      else if (cmd == CMD_RD_SLOT) cur_ff <= head_ff;
      if (cmd == CMD_FINISH) begin
         rsp_ff.status        <= status;
         rsp_ff.new_slot      <= new_slot_in;
         rsp_ff.removed_value <= removed_in;
         rsp_ff.in_order      <= order_in;
         rsp_ff.count         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= SLOT_W'(1);
         count_ff <= '0;
         order_ff <= 1'b1;
         idx_ff   <= '0;
      end else begin
         if (cmd == CMD_FINISH) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            free_ff  <= free_in;
            count_ff <= count_in;
            order_ff <= order_in;
         end
         case (cmd)
            CMD_CLEAR_WR, CMD_REB_WR: idx_ff <= idx_ff + SLOT_W'(1);
            CMD_RD_SLOT: idx_ff <= SLOT_W'(1);
            CMD_WALK_WR: idx_ff <= (idx_ff == count_ff) ? SLOT_W'(1) : idx_ff + SLOT_W'(1);
            default: ;
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/array_doubly_linked_list_engine_core.sv
// Channel   Ports                          Direction  Moves
// request   req_valid req_stall req_data   in         op, slot, value
// response  rsp_valid rsp_stall rsp_data   out        status, new_slot, removed_value,
//                                                     in_order, count
// Inserts and removes present their result after a read of the slot, a read of the free head,
// a check, three link writes and the finishing step.
// A failed operation skips the writes; the next item can be taken in the cycle after the finishing step.
// Linearize walks the list and then rewrites slots 1 to 255.
// After reset a clearing pass over all 256 slots initialises the store; no item is taken meanwhile.
// A waiting result does not block the next item; only the finish of that item waits.
module array_doubly_linked_list_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aldl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aldl_pkg::rsp_type rsp_data
);
   import aldl_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   aldl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   aldl_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
